[rtl/core/channel_gain_average_inverse_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the channel gain average and inverse block
// ---------------------------------------------------------------------------
`ifndef CHANNEL_GAIN_AVERAGE_INVERSE_ASSERT_SVH
`define CHANNEL_GAIN_AVERAGE_INVERSE_ASSERT_SVH

// condition holds at every edge out of reset
`define CGAI_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define CGAI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/cgai_pkg.sv]
// ---------------------------------------------------------------------------
// cgai_pkg
// Shared types, constants and step functions of the channel gain inverse.
// ---------------------------------------------------------------------------
package cgai_pkg;

  // scale numerators over two: 1.5 and 1.0
  localparam logic [1:0] NUM_MAGNIFY = 2'd3;
  localparam logic [1:0] NUM_UNITY   = 2'd2;

  localparam int DIV_STEPS       = 18;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

  // exponent of the quotient before the final one or two bit shift
  localparam logic [5:0] EXP_BASE = 6'd48;

  typedef struct packed {
    logic signed [15:0] avg_re;
    logic signed [15:0] avg_im;
    logic [31:0]        energy;
    logic               magnify;
    logic               last;
  } cgai_side_t;

  typedef struct packed {
    logic [31:0] dn;   // normalised divisor, msb set
    logic [31:0] rem;  // partial remainder, always below dn
    logic [17:0] quo;
    logic [4:0]  lz;   // leading zeros of the divisor
  } cgai_div_t;

  function automatic logic [4:0] lzc32(logic [31:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(31 - i);
    end
    return n;
  endfunction

  // one restoring division step, a zero shifted into the remainder
  function automatic cgai_div_t div_step(cgai_div_t d);
    cgai_div_t  o;
    logic [32:0] r2;
    logic        qbit;
    o    = d;
    r2   = {d.rem, 1'b0};
    qbit = 1'b0;
    if (r2 >= {1'b0, d.dn}) begin
      r2   = r2 - {1'b0, d.dn};
      qbit = 1'b1;
    end
    o.rem = r2[31:0];
    o.quo = {d.quo[16:0], qbit};
    return o;
  endfunction

endpackage

[rtl/core/cgai_front.sv]
// ---------------------------------------------------------------------------
// cgai_front
// Rounded average of the two gains, squares and energy over three stages.
// ---------------------------------------------------------------------------
module cgai_front import cgai_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] first_re,
  input  logic signed [15:0] first_im,
  input  logic signed [15:0] second_re,
  input  logic signed [15:0] second_im,
  input  logic               last_in,
  input  logic               magnify,
  output logic               f_valid,
  output cgai_side_t         f_side
);

  logic        v1, v2;
  cgai_side_t  s1, s2;
  logic [30:0] sq_re, sq_im;
  logic [16:0] sum_re, sum_im;
  logic signed [31:0] p_re, p_im;

  // (a + b + 1) >> 1, floor taken by dropping the lsb
  assign sum_re = {first_re[15], first_re} + {second_re[15], second_re} + 17'd1;
  assign sum_im = {first_im[15], first_im} + {second_im[15], second_im} + 17'd1;

  assign p_re = s1.avg_re * s1.avg_re;
  assign p_im = s1.avg_im * s1.avg_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      f_valid <= 1'b0;
    end else if (en) begin
      v1      <= in_valid;
      v2      <= v1;
      f_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.avg_re  <= sum_re[16:1];
      s1.avg_im  <= sum_im[16:1];
      s1.energy  <= 32'd0;
      s1.magnify <= magnify;
      s1.last    <= last_in;

      s2    <= s1;
      sq_re <= p_re[30:0];
      sq_im <= p_im[30:0];

      f_side.avg_re  <= s2.avg_re;
      f_side.avg_im  <= s2.avg_im;
      f_side.energy  <= {1'b0, sq_re} + {1'b0, sq_im};
      f_side.magnify <= s2.magnify;
      f_side.last    <= s2.last;
    end
  end

endmodule

[rtl/core/cgai_norm.sv]
// ---------------------------------------------------------------------------
// cgai_norm
// Forms energy + 1, counts its leading zeros and normalises the divisor.
// ---------------------------------------------------------------------------
module cgai_norm import cgai_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       f_valid,
  input  cgai_side_t f_side,
  output logic       n_valid,
  output cgai_side_t n_side,
  output cgai_div_t  n_div
);

  logic        v1, v2;
  cgai_side_t  s1, s2;
  logic [31:0] den1, den2;
  logic [4:0]  lz2;
  logic [1:0]  num;

  assign num = s2.magnify ? NUM_MAGNIFY : NUM_UNITY;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      n_valid <= 1'b0;
    end else if (en) begin
      v1      <= f_valid;
      v2      <= v1;
      n_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1   <= f_side;
      den1 <= f_side.energy + 32'd1;

      s2   <= s1;
      den2 <= den1;
      lz2  <= lzc32(den1);

      // quotient of num * 2^47 over dn, taken 18 bits from num * 2^29
      n_side    <= s2;
      n_div.dn  <= den2 << lz2;
      n_div.rem <= {1'b0, num, 29'd0};
      n_div.quo <= 18'd0;
      n_div.lz  <= lz2;
    end
  end

endmodule

[rtl/core/cgai_div.sv]
// ---------------------------------------------------------------------------
// cgai_div
// Pipelined restoring divider, two quotient bits per stage.
// ---------------------------------------------------------------------------
module cgai_div import cgai_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       n_valid,
  input  cgai_side_t n_side,
  input  cgai_div_t  n_div,
  output logic       d_valid,
  output cgai_side_t d_side,
  output cgai_div_t  d_div
);

  logic       valid [DIV_STAGES];
  cgai_side_t side  [DIV_STAGES];
  cgai_div_t  lane  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic       v_in;
    cgai_side_t s_in;
    cgai_div_t  l_in;
    cgai_div_t  l_out;

    if (k == 0) begin : g_head
      assign v_in = n_valid;
      assign s_in = n_side;
      assign l_in = n_div;
    end else begin : g_body
      assign v_in = valid[k-1];
      assign s_in = side[k-1];
      assign l_in = lane[k-1];
    end

    always_comb begin
      l_out = l_in;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        l_out = div_step(l_out);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= s_in;
        lane[k] <= l_out;
      end
    end
  end

  assign d_valid = valid[DIV_STAGES-1];
  assign d_side  = side[DIV_STAGES-1];
  assign d_div   = lane[DIV_STAGES-1];

endmodule

[rtl/core/channel_gain_average_inverse.sv]
// ---------------------------------------------------------------------------
// channel_gain_average_inverse
// Averages two channel estimates per subcarrier and gives the conjugate,
// energy and a truncated reciprocal scale / (energy + 1).
// ---------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    first_re/im, second_re/im, last_in
//  out      source     out_valid / out_stall  avg_re/im, conj_im, energy, recip_*, last_out
//  cfg      sink       cfg_write              cfg_data -> magnify_enable
//
//  One word accepted per cycle unless a valid output word is stalled. The path runs
//  through the three front stages, three normalising stages, nine divider stages
//  (two quotient bits each) and the output register.
//  Reset clears all valid bits and sets magnify_enable.
//  A stall on the output while out_valid is high freezes the whole pipeline and raises in_stall.
// ---------------------------------------------------------------------------
module channel_gain_average_inverse import cgai_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] first_re,
  input  logic signed [15:0] first_im,
  input  logic signed [15:0] second_re,
  input  logic signed [15:0] second_im,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] avg_re,
  output logic signed [15:0] avg_im,
  output logic signed [15:0] conj_im,
  output logic [31:0]        energy,
  output logic [15:0]        recip_mantissa,
  output logic [5:0]         recip_exponent,
  output logic               last_out
);

`include "channel_gain_average_inverse_assert.svh"

  logic       magnify_enable;
  logic       en;
  logic       f_valid, n_valid, d_valid;
  cgai_side_t f_side, n_side, d_side;
  cgai_div_t  n_div, d_div;
  logic [15:0] mant;
  logic [5:0]  expo;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnify_enable <= 1'b1;
    end else if (cfg_write) begin
      magnify_enable <= cfg_data;
    end
  end

  cgai_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .first_re  (first_re),
    .first_im  (first_im),
    .second_re (second_re),
    .second_im (second_im),
    .last_in   (last_in),
    .magnify   (magnify_enable),
    .f_valid   (f_valid),
    .f_side    (f_side)
  );

  cgai_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .f_valid (f_valid),
    .f_side  (f_side),
    .n_valid (n_valid),
    .n_side  (n_side),
    .n_div   (n_div)
  );

  cgai_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .n_valid (n_valid),
    .n_side  (n_side),
    .n_div   (n_div),
    .d_valid (d_valid),
    .d_side  (d_side),
    .d_div   (d_div)
  );

  // quotient lies in [2^16, 3 * 2^16]: drop two bits if bit 17 is set, else one
  always_comb begin
    if (d_div.quo[17]) begin
      mant = d_div.quo[17:2];
      expo = EXP_BASE - {1'b0, d_div.lz} - 6'd2;
    end else begin
      mant = d_div.quo[16:1];
      expo = EXP_BASE - {1'b0, d_div.lz} - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      avg_re         <= d_side.avg_re;
      avg_im         <= d_side.avg_im;
      conj_im        <= 16'(~d_side.avg_im + 16'sd1);
      energy         <= d_side.energy;
      recip_mantissa <= mant;
      recip_exponent <= expo;
      last_out       <= d_side.last;
    end
  end

  `CGAI_ASSERT_IMPL(a_mant_norm, out_valid, recip_mantissa[15], "mantissa not normalised")
  `CGAI_ASSERT_IMPL(a_exp_range, out_valid,
    (recip_exponent >= 6'd15) && (recip_exponent <= 6'd47), "exponent out of range")
  `CGAI_ASSERT_IMPL(a_conj, out_valid, 16'(conj_im + avg_im) == 16'd0, "conjugate mismatch")
  `CGAI_ASSERT_IMPL(a_zero_energy, out_valid && (energy == 32'd0),
    recip_exponent == 6'd15, "zero energy exponent wrong")
  `CGAI_ASSERT_ALWAYS(a_energy_max, !out_valid || (energy <= 32'h8000_0000), "energy too large")

endmodule

[tb/sv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for channel_gain_average_inverse. Subcarrier words are
// driven over the valid/stall input. Each accepted word is predicted in the
// bench: the rounded average, the conjugate, the energy and the truncated
// reciprocal. Results are checked in order against that prediction. The
// sender idles and the receiver stalls at random, and the gain scale
// register is switched between phases.
// ---------------------------------------------------------------------------
module testbench import cgai_pkg::*;;

  localparam int unsigned PIPE_LATENCY = 16;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned MANT_FLOOR   = 32768;
  localparam int unsigned EXP_LOW      = 15;
  localparam int unsigned EXP_HIGH     = 48;

  typedef struct packed {
    logic signed [15:0] first_re;
    logic signed [15:0] first_im;
    logic signed [15:0] second_re;
    logic signed [15:0] second_im;
    logic               last;
  } gain_word_t;

  typedef struct packed {
    logic signed [15:0] avg_re;
    logic signed [15:0] avg_im;
    logic signed [15:0] conj_im;
    logic [31:0]        energy;
    logic [15:0]        mant;
    logic [5:0]         expo;
    logic               last;
  } estimate_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic               cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] first_re;
  logic signed [15:0] first_im;
  logic signed [15:0] second_re;
  logic signed [15:0] second_im;
  logic               last_in;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] avg_re;
  logic signed [15:0] avg_im;
  logic signed [15:0] conj_im;
  logic [31:0]        energy;
  logic [15:0]        recip_mantissa;
  logic [5:0]         recip_exponent;
  logic               last_out;

  estimate_t   pending_estimates[$];
  logic        magnify_setting = 1'b1;
  bit          rx_random_en = 1'b1;
  int unsigned rx_hold_request = 0;
  int unsigned words_sent = 0;
  int unsigned estimates_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  channel_gain_average_inverse dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .first_re       (first_re),
    .first_im       (first_im),
    .second_re      (second_re),
    .second_im      (second_im),
    .last_in        (last_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .avg_re         (avg_re),
    .avg_im         (avg_im),
    .conj_im        (conj_im),
    .energy         (energy),
    .recip_mantissa (recip_mantissa),
    .recip_exponent (recip_exponent),
    .last_out       (last_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // averaged gain, conjugate, energy and scale / (energy + 1) for one word
  function automatic estimate_t estimate_channel(gain_word_t w, logic magnify);
    estimate_t         r;
    int                re;
    int                im;
    longint unsigned   en;
    longint unsigned   den;
    longint unsigned   numer;
    longint unsigned   q;
    bit                found;
    re = (int'($signed(w.first_re)) + int'($signed(w.second_re)) + 1) >>> 1;
    im = (int'($signed(w.first_im)) + int'($signed(w.second_im)) + 1) >>> 1;
    r.avg_re  = re[15:0];
    r.avg_im  = im[15:0];
    r.conj_im = 16'(-im);
    en = longint'(re) * longint'(re) + longint'(im) * longint'(im);
    r.energy = en[31:0];
    den   = en + 1;
    numer = magnify ? longint'(NUM_MAGNIFY) : longint'(NUM_UNITY);
    r.mant = 16'(MANT_FLOOR);
    r.expo = 6'(EXP_HIGH);
    found  = 1'b0;
    // smallest exponent that brings the truncated quotient up to 2^15
    for (int unsigned e = EXP_LOW; e <= EXP_HIGH; e++) begin
      q = (numer << (e - 1)) / den;
      if (!found && q >= MANT_FLOOR) begin
        r.mant = q[15:0];
        r.expo = 6'(e);
        found  = 1'b1;
      end
    end
    r.last = w.last;
    return r;
  endfunction

  function automatic gain_word_t make_word(int fr, int fi, int sr, int si, bit l);
    gain_word_t w;
    w.first_re  = 16'(fr);
    w.first_im  = 16'(fi);
    w.second_re = 16'(sr);
    w.second_im = 16'(si);
    w.last      = l;
    return w;
  endfunction

  function automatic logic signed [15:0] random_part();
    logic signed [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 3))
      1: v = v >>> $urandom_range(1, 15);
      2: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'hffff;
          3: v = 16'h0000;
          default: v = 16'h8001;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  // second symbol either independent or close to the first
  function automatic gain_word_t random_word();
    gain_word_t w;
    w.first_re = random_part();
    w.first_im = random_part();
    if ($urandom_range(0, 1) == 0) begin
      w.second_re = random_part();
      w.second_im = random_part();
    end else begin
      w.second_re = w.first_re + 16'($urandom_range(0, 6)) - 16'd3;
      w.second_im = w.first_im + 16'($urandom_range(0, 6)) - 16'd3;
    end
    w.last = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return $urandom_range(1, 3);
    if (pick < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called and returns at a falling edge
  task automatic send_word(input gain_word_t w);
    in_valid  <= 1'b1;
    first_re  <= w.first_re;
    first_im  <= w.first_im;
    second_re <= w.second_re;
    second_im <= w.second_im;
    last_in   <= w.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_estimates.push_back(estimate_channel(w, magnify_setting));
    words_sent++;
    @(negedge clk);
  endtask

  // payload scrambled while idle; the block must ignore it
  task automatic idle_sender(input int unsigned cycles);
    in_valid  <= 1'b0;
    first_re  <= 16'($urandom);
    first_im  <= 16'($urandom);
    second_re <= 16'($urandom);
    second_im <= 16'($urandom);
    last_in   <= 1'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_magnify(input logic value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    magnify_setting = value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_corner_set();
    send_word(make_word(0, 0, 0, 0, 1'b0));                  // zero energy
    send_word(make_word(-1, -1, 0, 0, 1'b1));                // rounds to zero
    send_word(make_word(-32768, 32767, 32767, -32768, 1'b0));
    send_word(make_word(-32768, -32768, -32768, -32768, 1'b1)); // energy 2^31
    send_word(make_word(32767, 32767, 32767, 32767, 1'b0));
    send_word(make_word(32767, -32768, 32767, -32768, 1'b1)); // conj wraps
    send_word(make_word(-3, -2, 0, 0, 1'b0));                 // floor on negatives
    send_word(make_word(1, 0, 0, 0, 1'b1));
    send_word(make_word(-32768, 0, -32767, 0, 1'b0));
    send_word(make_word(16384, 16384, 16385, 16383, 1'b1));
    send_word(make_word(0, 2, 0, 1, 1'b0));
    wait_drain();
  endtask

  task automatic test_corners_magnified();
    send_corner_set();
  endtask

  task automatic test_corners_unity();
    write_magnify(1'b0);
    send_corner_set();
  endtask

  task automatic test_random_traffic(input logic magnify, input int unsigned count);
    write_magnify(magnify);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0) idle_sender(idle_length());
      if ($urandom_range(0, 99) == 0) wait_drain();
      send_word(random_word());
    end
    wait_drain();
  endtask

  task automatic test_full_rate();
    rx_random_en = 1'b0;
    repeat (80) send_word(random_word());
    wait_drain();
    rx_random_en = 1'b1;
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_output_hold();
    rx_random_en    = 1'b0;
    rx_hold_request = 200;
    repeat (60) send_word(random_word());
    wait_drain();
    rx_random_en = 1'b1;
  endtask

  initial begin : result_receiver
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_request != 0) begin
        n = rx_hold_request;
        rx_hold_request = 0;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_random_en && $urandom_range(0, 3) == 0) begin
        n = idle_length();
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    estimate_t exp_est;
    if (!rst && out_valid && !out_stall) begin
      if (pending_estimates.size() == 0) begin
        $error("result word with nothing outstanding");
        mismatches++;
      end else begin
        exp_est = pending_estimates.pop_front();
        check_field("avg_re", 32'(exp_est.avg_re), 32'(avg_re));
        check_field("avg_im", 32'(exp_est.avg_im), 32'(avg_im));
        check_field("conj_im", 32'(exp_est.conj_im), 32'(conj_im));
        check_field("energy", exp_est.energy, energy);
        check_field("recip_mantissa", 32'(exp_est.mant), 32'(recip_mantissa));
        check_field("recip_exponent", 32'(exp_est.expo), 32'(recip_exponent));
        check_field("last_out", 32'(exp_est.last), 32'(last_out));
        estimates_checked++;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    first_re  = '0;
    first_im  = '0;
    second_re = '0;
    second_im = '0;
    last_in   = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_corners_magnified();
    test_corners_unity();
    test_random_traffic(1'b1, 300);
    test_random_traffic(1'b0, 300);
    test_output_hold();
    test_full_rate();
    test_random_traffic(1'b1, 300);

    if (pending_estimates.size() != 0) begin
      $error("%0d results never arrived", pending_estimates.size());
      mismatches++;
    end
    $display("Checked %0d estimates from %0d subcarrier words at both gain scales.",
             estimates_checked, words_sent);
    $display("Traffic: corner gains, random gaps, full rate and a long output hold.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/cgai_pkg.sv
rtl/core/cgai_front.sv
rtl/core/cgai_norm.sv
rtl/core/cgai_div.sv
rtl/core/channel_gain_average_inverse.sv
tb/sv/testbench.sv
